[rtl/line_numbered_resend_window_unit_defines.svh]
// Assertion macros for the line-numbered resend window unit
`ifndef LINE_NUMBERED_RESEND_WINDOW_UNIT_DEFINES_SVH
`define LINE_NUMBERED_RESEND_WINDOW_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define LNRW_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define LNRW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/lnrw_pkg.sv]
// Package: widths, codes and types of the line-numbered resend window unit
`timescale 1ns / 1ps

package lnrw_pkg;

    localparam int WINDOW_DEPTH = 16;
    localparam int AW           = $clog2(WINDOW_DEPTH);
    localparam int CW           = $clog2(WINDOW_DEPTH + 1);

    localparam int CMD_W    = 2;
    localparam int LINE_W   = 16;
    localparam int NEXT_W   = 17;
    localparam int PAY_W    = 32;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 3;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam int CFG_IDX_W = 1;

    localparam logic [CMD_W-1:0] CMD_SEND   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_OK     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESEND = 2'd2;

    localparam logic [KIND_W-1:0] KIND_LINE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RESET  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STATUS = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BUSY       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_OK     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_RESEND = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LINE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LINE = 1'd1;

    localparam logic [LINE_W-1:0] MAX_LINE_RST   = 16'd65000;
    localparam logic [LINE_W-1:0] RESET_LINE_RST = 16'd0;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [LINE_W-1:0] line_number;
        logic [PAY_W-1:0]  payload;
    } t_desc;

    typedef struct packed {
        logic  valid;
        t_desc desc;
    } t_q_head;

    typedef struct packed {
        logic [LINE_W-1:0] max_line;
        logic [LINE_W-1:0] reset_line;
    } t_cfg;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [LINE_W-1:0]   out_line;
        logic [PAY_W-1:0]    out_payload;
        logic [STATUS_W-1:0] status;
        logic                last;
    } t_res;

    function automatic logic [AW-1:0] wrap_ptr(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [CW:0] s;
        s = {{(CW + 1 - AW){1'b0}}, base} + {1'b0, off};
        if (s >= (CW + 1)'(WINDOW_DEPTH)) begin
            s = s - (CW + 1)'(WINDOW_DEPTH);
        end
        return s[AW-1:0];
    endfunction

endpackage

[rtl/lnrw_in_if.sv]
// Command channel interface
`timescale 1ns / 1ps

interface lnrw_in_if import lnrw_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [LINE_W-1:0] line_number;
    logic [PAY_W-1:0]  payload;

    modport source(output valid, command, line_number, payload, input ready);
    modport sink(input valid, command, line_number, payload, output ready);
endinterface

[rtl/lnrw_out_if.sv]
// Result channel interface
`timescale 1ns / 1ps

interface lnrw_out_if import lnrw_pkg::*;;
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [LINE_W-1:0]   out_line;
    logic [PAY_W-1:0]    out_payload;
    logic [STATUS_W-1:0] status;
    logic                last;

    modport source(output valid, kind, out_line, out_payload, status, last, input ready);
    modport sink(input valid, kind, out_line, out_payload, status, last, output ready);
endinterface

[rtl/lnrw_ram.sv]
// Generic single-write, single-read RAM with registered read
`timescale 1ns / 1ps

module lnrw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/lnrw_front.sv]
// Front end: accept command beats, classify them and queue them for the back end
`timescale 1ns / 1ps

module lnrw_front import lnrw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lnrw_in_if.sink     i_cmd,
    input  logic        i_pop,
    output t_q_head     o_q
);

    logic [Q_CW-1:0] r_cnt,  n_cnt;
    logic [Q_AW-1:0] r_wptr, n_wptr;
    logic [Q_AW-1:0] r_rptr, n_rptr;
    t_desc           r_q [Q_DEPTH];
    t_desc           in_desc;
    logic            push;
    logic            pop;

    function automatic logic [Q_AW-1:0] ptr_inc(input logic [Q_AW-1:0] p);
        return (p == Q_AW'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign i_cmd.ready = (r_cnt != Q_CW'(Q_DEPTH));
    assign push        = i_cmd.valid && i_cmd.ready;
    assign pop         = i_pop && (r_cnt != '0);

    always_comb begin
        in_desc.command     = i_cmd.command;
        in_desc.line_number = i_cmd.line_number;
        in_desc.payload     = (i_cmd.command == CMD_SEND) ? i_cmd.payload : '0;
    end

    always_comb begin
        n_wptr = push ? ptr_inc(r_wptr) : r_wptr;
        n_rptr = pop ? ptr_inc(r_rptr) : r_rptr;
        n_cnt  = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!push && pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_wptr <= '0;
            r_rptr <= '0;
        end else begin
            r_cnt  <= n_cnt;
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= in_desc;
        end
    end

    assign o_q.valid = (r_cnt != '0);
    assign o_q.desc  = r_q[r_rptr];

endmodule

[rtl/lnrw_back.sv]
// Back end: window state, payload store, replay sequencer and result register
`timescale 1ns / 1ps

module lnrw_back import lnrw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_q_head     i_q,
    output logic        o_pop,
    lnrw_out_if.source  o_res
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_RESET2 = 2'd1;
    localparam logic [1:0] S_RD     = 2'd2;
    localparam logic [1:0] S_EMIT   = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [AW-1:0]     r_head,  n_head;
    logic [LINE_W-1:0] r_front, n_front;
    logic [NEXT_W-1:0] r_next,  n_next;
    logic [AW-1:0]     r_idx,   n_idx;
    logic              r_out_valid, n_out_valid;
    t_res              r_out, n_out;

    logic              slot_free;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [PAY_W-1:0]  ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [PAY_W-1:0]  ram_rdata;
    logic [LINE_W-1:0] line;
    logic [LINE_W-1:0] diff;
    logic [CW-1:0]     rc;
    logic              ok_good;
    logic              replay_last;

    assign slot_free   = !r_out_valid || o_res.ready;
    assign line        = i_q.desc.line_number;
    assign diff        = line - r_front;
    assign rc          = CW'(diff + 1'b1);
    assign ok_good     = (line == r_front)
                      || ((line > r_front) && ({1'b0, line} < r_next)
                          && ({1'b0, diff} + 1'b1 <= (LINE_W + 1)'(r_count)));
    assign ram_raddr   = wrap_ptr(r_head, CW'(r_idx));
    assign replay_last = (CW'(r_idx) + 1'b1 == r_count);

    lnrw_ram #(
        .WIDTH(PAY_W),
        .DEPTH(WINDOW_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_head      = r_head;
        n_front     = r_front;
        n_next      = r_next;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out       = r_out;
        o_pop       = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = wrap_ptr(r_head, r_count);
        ram_wdata   = i_q.desc.payload;

        case (r_state)
            S_IDLE: begin
                if (i_q.valid && slot_free) begin
                    o_pop       = 1'b1;
                    n_out_valid = 1'b1;
                    n_out       = '{kind: KIND_STATUS, out_line: '0, out_payload: '0,
                                    status: ST_DONE, last: 1'b1};
                    case (i_q.desc.command)
                        CMD_SEND: begin
                            if ((r_count == CW'(WINDOW_DEPTH))
                                    || (r_next > {1'b0, i_cfg.max_line})) begin
                                n_out.status = ST_BUSY;
                            end else begin
                                ram_we            = 1'b1;
                                n_out.kind        = KIND_LINE;
                                n_out.out_line    = r_next[LINE_W-1:0];
                                n_out.out_payload = i_q.desc.payload;
                                if (r_count == '0) begin
                                    n_front = r_next[LINE_W-1:0];
                                end
                                n_count = r_count + 1'b1;
                                n_next  = r_next + 1'b1;
                            end
                        end
                        CMD_OK: begin
                            if (r_count == '0) begin
                                n_out.status = ST_EMPTY;
                            end else if (!ok_good) begin
                                n_out.status = ST_BAD_OK;
                            end else begin
                                n_count = r_count - rc;
                                n_head  = wrap_ptr(r_head, rc);
                                n_front = r_front + LINE_W'(rc);
                                if (line == i_cfg.max_line) begin
                                    n_out.kind     = KIND_RESET;
                                    n_out.out_line = i_cfg.reset_line;
                                    n_out.last     = 1'b0;
                                    n_front        = LINE_W'(1);
                                    n_next         = NEXT_W'(1);
                                    n_state        = S_RESET2;
                                end
                            end
                        end
                        CMD_RESEND: begin
                            if (r_count == '0) begin
                                n_out.status = ST_EMPTY;
                            end else if (line > i_cfg.max_line) begin
                                n_out.kind     = KIND_RESET;
                                n_out.out_line = i_cfg.reset_line;
                            end else if (line < r_front) begin
                                n_out.kind     = KIND_RESET;
                                n_out.out_line = r_front;
                            end else if (diff >= LINE_W'(r_count)) begin
                                n_out.status = ST_BAD_RESEND;
                            end else begin
                                n_out_valid = r_out_valid && !o_res.ready;
                                n_out       = r_out;
                                n_idx       = AW'(diff);
                                n_state     = S_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RESET2: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{kind: KIND_RESET, out_line: i_cfg.reset_line,
                                    out_payload: '0, status: ST_DONE, last: 1'b1};
                    n_state     = S_IDLE;
                end
            end
            S_RD: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{kind: KIND_LINE, out_line: r_front + LINE_W'(r_idx),
                                    out_payload: ram_rdata, status: ST_DONE,
                                    last: replay_last};
                    if (replay_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_head      <= '0;
            r_front     <= LINE_W'(1);
            r_next      <= NEXT_W'(1);
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_head      <= n_head;
            r_front     <= n_front;
            r_next      <= n_next;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.kind        = r_out.kind;
    assign o_res.out_line    = r_out.out_line;
    assign o_res.out_payload = r_out.out_payload;
    assign o_res.status      = r_out.status;
    assign o_res.last        = r_out.last;

endmodule

[rtl/line_numbered_resend_window_unit.sv]
// Top level of the line-numbered resend window unit
//
//   channel  | dir | beat contents
//   ---------+-----+------------------------------------------------------
//   i_cmd    | in  | command, line_number, payload
//   o_res    | out | kind, out_line, out_payload, status, last
//   i_cfg_*  | in  | write enable, register index, write data (no handshake)
//
// Send, ok and unknown commands give their result in the cycle after they leave the queue.
// A resend replays the held entries from the requested line to the newest, each through
// a registered store read and then the result register.
// Reset clears the queue, counters and line numbers; stored payloads stay unknown.
// A two-beat queue keeps taking commands while o_res is stalled, until it is full.
`timescale 1ns / 1ps

module line_numbered_resend_window_unit import lnrw_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    lnrw_in_if.sink              i_cmd,
    lnrw_out_if.source           o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [LINE_W-1:0]    i_cfg_data
);

    t_cfg    r_cfg;
    t_q_head q_head;
    logic    pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_line   <= MAX_LINE_RST;
            r_cfg.reset_line <= RESET_LINE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_LINE:   r_cfg.max_line   <= i_cfg_data;
                CFG_RESET_LINE: r_cfg.reset_line <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    lnrw_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .i_pop   (pop),
        .o_q     (q_head)
    );

    lnrw_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_q     (q_head),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

[rtl/lnrw_checker.sv]
// Port-level checker for the line-numbered resend window unit, with its bind
`timescale 1ns / 1ps
`include "line_numbered_resend_window_unit_defines.svh"

module lnrw_checker import lnrw_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_ready,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [LINE_W-1:0]   i_line,
    input  logic [PAY_W-1:0]    i_payload,
    input  logic [STATUS_W-1:0] i_status
);

    `LNRW_ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid, "result beat dropped while stalled")
    `LNRW_ASSERT_IMP(a_line_done, i_clk, i_rst_n, i_valid && (i_kind == KIND_LINE), i_status == ST_DONE, "line beat with nonzero status")
    `LNRW_ASSERT_IMP(a_status_clean, i_clk, i_rst_n, i_valid && (i_kind == KIND_STATUS), (i_line == '0) && (i_payload == '0), "status beat with line or payload")
    `LNRW_ASSERT_IMP(a_reset_clean, i_clk, i_rst_n, i_valid && (i_kind == KIND_RESET), (i_payload == '0) && (i_status == ST_DONE), "reset beat with payload or status")

endmodule

bind line_numbered_resend_window_unit lnrw_checker u_lnrw_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (o_res.valid),
    .i_ready   (o_res.ready),
    .i_kind    (o_res.kind),
    .i_line    (o_res.out_line),
    .i_payload (o_res.out_payload),
    .i_status  (o_res.status)
);

[dv/line_numbered_resend_window_unit_test.sv]
// Testbench for the line-numbered resend window unit: predicts every result beat and checks it
`timescale 1ns / 1ps

module line_numbered_resend_window_unit_test;
    import lnrw_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [LINE_W-1:0]    i_cfg_data;

    lnrw_in_if  cmd_if ();
    lnrw_out_if res_if ();

    line_numbered_resend_window_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    logic [PAY_W-1:0] win_payload [WINDOW_DEPTH];
    int unsigned      win_held = 0;
    int unsigned      win_front = 1;
    int unsigned      win_next = 1;
    int unsigned      cfg_max_line = 65000;
    int unsigned      cfg_reset_line = 0;

    t_desc pending_cmds [$];
    t_res  expected_results [$];

    bit steady = 1'b0;
    int failures = 0;
    int commands_queued = 0;
    int commands_accepted = 0;
    int results_checked = 0;
    int settings_applied = 0;
    int lines_replayed = 0;
    int wraps_seen = 0;
    int sends_refused = 0;

    always #10 i_clk = ~i_clk;

    function automatic t_res make_result(input logic [KIND_W-1:0] kind, input int unsigned line,
                                         input logic [PAY_W-1:0] pay,
                                         input logic [STATUS_W-1:0] st);
        t_res r;
        r.kind        = kind;
        r.out_line    = LINE_W'(line);
        r.out_payload = pay;
        r.status      = st;
        r.last        = 1'b0;
        return r;
    endfunction

    function automatic void predict_window(input t_desc d);
        t_res        outs [$];
        int unsigned line_n;
        int unsigned rc;
        int unsigned idx;
        line_n = 32'(d.line_number);
        case (d.command)
            CMD_SEND: begin
                if (win_held >= WINDOW_DEPTH || win_next > cfg_max_line) begin
                    outs.push_back(make_result(KIND_STATUS, 0, '0, ST_BUSY));
                    sends_refused++;
                end else begin
                    win_payload[win_held] = d.payload;
                    if (win_held == 0) begin
                        win_front = win_next & 32'hFFFF;
                    end
                    outs.push_back(make_result(KIND_LINE, win_next, d.payload, ST_DONE));
                    win_held++;
                    win_next = (win_next + 1) & 32'h1FFFF;
                end
            end
            CMD_OK: begin
                if (win_held == 0) begin
                    outs.push_back(make_result(KIND_STATUS, 0, '0, ST_EMPTY));
                end else if (line_n != win_front && !(line_n > win_front && line_n < win_next
                             && line_n - win_front + 1 <= win_held)) begin
                    outs.push_back(make_result(KIND_STATUS, 0, '0, ST_BAD_OK));
                end else begin
                    rc = (line_n == win_front) ? 1 : line_n - win_front + 1;
                    for (int i = 0; i + rc < win_held; i++) begin
                        win_payload[i] = win_payload[i + rc];
                    end
                    win_held  = win_held - rc;
                    win_front = (win_front + rc) & 32'hFFFF;
                    if (line_n == cfg_max_line) begin
                        outs.push_back(make_result(KIND_RESET, cfg_reset_line, '0, ST_DONE));
                        outs.push_back(make_result(KIND_RESET, cfg_reset_line, '0, ST_DONE));
                        win_next  = 1;
                        win_front = 1;
                        wraps_seen++;
                    end else begin
                        outs.push_back(make_result(KIND_STATUS, 0, '0, ST_DONE));
                    end
                end
            end
            CMD_RESEND: begin
                if (win_held == 0) begin
                    outs.push_back(make_result(KIND_STATUS, 0, '0, ST_EMPTY));
                end else if (line_n > cfg_max_line) begin
                    outs.push_back(make_result(KIND_RESET, cfg_reset_line, '0, ST_DONE));
                end else if (line_n < win_front) begin
                    outs.push_back(make_result(KIND_RESET, win_front, '0, ST_DONE));
                end else begin
                    idx = line_n - win_front;
                    if (idx >= win_held) begin
                        outs.push_back(make_result(KIND_STATUS, 0, '0, ST_BAD_RESEND));
                    end else begin
                        for (int unsigned i = idx; i < win_held; i++) begin
                            outs.push_back(make_result(KIND_LINE, (win_front + i) & 32'hFFFF,
                                                       win_payload[i], ST_DONE));
                            lines_replayed++;
                        end
                    end
                end
            end
            default: begin
                outs.push_back(make_result(KIND_STATUS, 0, '0, ST_DONE));
            end
        endcase
        outs[outs.size() - 1].last = 1'b1;
        foreach (outs[i]) begin
            expected_results.push_back(outs[i]);
        end
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    task automatic queue_command(input logic [CMD_W-1:0] cmd, input int unsigned line,
                                 input logic [PAY_W-1:0] pay);
        t_desc d;
        d.command     = cmd;
        d.line_number = LINE_W'(line);
        d.payload     = pay;
        pending_cmds.push_back(d);
        commands_queued++;
    endtask

    task automatic wait_for_drain();
        do begin
            @(negedge i_clk);
        end while (pending_cmds.size() != 0 || cmd_if.valid || expected_results.size() != 0);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= LINE_W'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_MAX_LINE) begin
            cfg_max_line = value & 32'hFFFF;
        end else begin
            cfg_reset_line = value & 32'hFFFF;
        end
        settings_applied++;
    endtask

    // sends, then a resend and sometimes an ok aimed inside the window, then a little noise
    task automatic queue_window_burst();
        int unsigned sends;
        int unsigned room;
        int unsigned held_after;
        int unsigned front_after;
        int unsigned last_sent;
        int unsigned pick;
        sends = ($urandom_range(9) == 0) ? WINDOW_DEPTH + 1 : $urandom_range(8, 1);
        room  = WINDOW_DEPTH - win_held;
        if (win_next > cfg_max_line) begin
            room = 0;
        end else if (cfg_max_line + 1 - win_next < room) begin
            room = cfg_max_line + 1 - win_next;
        end
        held_after  = win_held + ((sends < room) ? sends : room);
        front_after = (win_held == 0) ? win_next : win_front;
        repeat (sends) begin
            queue_command(CMD_SEND, $urandom, $urandom);
        end
        if (held_after > 0) begin
            last_sent = front_after + held_after - 1;
            queue_command(CMD_RESEND, front_after + $urandom_range(held_after - 1), $urandom);
            if ($urandom_range(9) >= 3) begin
                pick = $urandom_range(1) ? last_sent
                                         : front_after + $urandom_range(held_after - 1);
                queue_command(CMD_OK, pick, $urandom);
            end
        end
        repeat ($urandom_range(2)) begin
            queue_command(CMD_W'($urandom_range(3)), $urandom_range(65535), $urandom);
        end
    endtask

    always @(posedge i_clk) begin
        t_desc beat;
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else begin
            if (cmd_if.valid && cmd_if.ready) begin
                predict_window({cmd_if.command, cmd_if.line_number, cmd_if.payload});
                commands_accepted++;
            end
            if (!cmd_if.valid || cmd_if.ready) begin
                if (pending_cmds.size() != 0 && (steady || $urandom_range(99) >= 34)) begin
                    beat = pending_cmds.pop_front();
                    cmd_if.valid       <= 1'b1;
                    cmd_if.command     <= beat.command;
                    cmd_if.line_number <= beat.line_number;
                    cmd_if.payload     <= beat.payload;
                end else begin
                    cmd_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                results_checked++;
                if (expected_results.size() == 0) begin
                    $error("result beat with nothing expected: kind %0d line %0d status %0d",
                           res_if.kind, res_if.out_line, res_if.status);
                    failures++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("kind", 32'(want.kind), 32'(res_if.kind));
                    check_field("out_line", 32'(want.out_line), 32'(res_if.out_line));
                    check_field("out_payload", want.out_payload, res_if.out_payload);
                    check_field("status", 32'(want.status), 32'(res_if.status));
                    check_field("last", 32'(want.last), 32'(res_if.last));
                end
            end
            res_if.ready <= steady || ($urandom_range(99) >= 34);
        end
    end

    initial begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int chunk;
        int unsigned new_max;
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = CFG_MAX_LINE;
        i_cfg_data         = '0;
        cmd_if.valid       = 1'b0;
        cmd_if.command     = CMD_SEND;
        cmd_if.line_number = '0;
        cmd_if.payload     = '0;
        res_if.ready       = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_command(CMD_OK, 1, '0);
        queue_command(CMD_RESEND, 1, '0);
        queue_command(CMD_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
        queue_command(CMD_SEND, 0, 32'h0000_0000);
        queue_command(CMD_SEND, 0, 32'hFFFF_FFFF);
        queue_command(CMD_SEND, 16'hFFFF, 32'hA5A5_5A5A);
        queue_command(CMD_RESEND, 1, '0);
        queue_command(CMD_RESEND, 0, '0);
        queue_command(CMD_RESEND, 16'hFFFF, '0);
        queue_command(CMD_RESEND, 4, '0);
        queue_command(CMD_OK, 0, '0);
        queue_command(CMD_OK, 2, '0);
        queue_command(CMD_OK, 3, '0);
        wait_for_drain();

        write_register(CFG_MAX_LINE, 4);
        write_register(CFG_RESET_LINE, 16'hFFFF);
        queue_command(CMD_SEND, 0, 32'h1234_5678);
        queue_command(CMD_SEND, 0, 32'h8765_4321);
        queue_command(CMD_OK, 4, '0);
        wait_for_drain();

        write_register(CFG_MAX_LINE, 1);
        write_register(CFG_RESET_LINE, 0);
        queue_command(CMD_SEND, 0, 32'hDEAD_BEEF);
        queue_command(CMD_SEND, 0, 32'hCAFE_F00D);
        queue_command(CMD_OK, 1, '0);
        wait_for_drain();

        write_register(CFG_MAX_LINE, 16'hFFFF);
        write_register(CFG_RESET_LINE, 16'h5A5A);

        chunk = 0;
        while (commands_queued < 165) begin
            steady = (chunk >= 6 && chunk < 10);
            queue_window_burst();
            wait_for_drain();
            chunk++;
            if (chunk % 3 == 0) begin
                if (chunk % 9 == 0) begin
                    new_max = 16'hFFFF;
                end else begin
                    new_max = win_next + $urandom_range(20);
                    if (new_max > 16'hFFFF) begin
                        new_max = 16'hFFFF;
                    end
                end
                write_register(CFG_MAX_LINE, new_max);
                case ($urandom_range(2))
                    0:       write_register(CFG_RESET_LINE, 0);
                    1:       write_register(CFG_RESET_LINE, 16'hFFFF);
                    default: write_register(CFG_RESET_LINE, $urandom_range(65535));
                endcase
            end
        end
        steady = 1'b0;

        wait_for_drain();
        repeat (2 * WINDOW_DEPTH + 8) @(posedge i_clk);
        $display("Checked %0d result beats from %0d commands across %0d register writes",
                 results_checked, commands_accepted, settings_applied);
        $display("Window saw %0d replayed lines, %0d numbering wraps, %0d refused sends",
                 lines_replayed, wraps_seen, sends_refused);
        if (failures == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
